// ===== design/stack_machine_execute_unit_assert.svh =====
// Assertion macros for the stack machine execute unit.
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define SMEU_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define SMEU_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/smeu_pkg.sv =====
package smeu_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 128;
  localparam int unsigned VAR_COUNT_DEF   = 256;
  localparam int unsigned PROG_DEPTH_DEF  = 1024;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned VIDX_W          = 8;
  localparam int unsigned TGT_W           = 10;
  // wide enough for a program depth of up to 131070 plus one
  localparam int unsigned PC_CMP_W        = 17;

  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,  OP_CONST = 4'd1,  OP_POP   = 4'd2,  OP_STORE = 4'd3,
    OP_LOAD  = 4'd4,  OP_ADD   = 4'd5,  OP_SUB   = 4'd6,  OP_MUL   = 4'd7,
    OP_DIV   = 4'd8,  OP_PRINT = 4'd9,  OP_INC   = 4'd10, OP_GOTO  = 4'd11,
    OP_IFEQ  = 4'd12, OP_IFNE  = 4'd13, OP_IFLT  = 4'd14, OP_IFGT  = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_EMPTY   = 2'd2,
    ERR_DIVZERO = 2'd3
  } err_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic clr;
    logic commit;
    logic push;
    logic push_var;
    logic pop1;
    logic pop2;
    logic alu_wr;
    logic div_start;
    logic div_wr;
    logic var_wr_tos;
    logic var_wr_inc;
    logic branch;
    logic print;
    err_t err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic sp_zero;
    logic sp_lt2;
    logic sp_full;
    logic a_zero;
    logic b_lt_a;
    logic a_lt_b;
    logic div_done;
    logic clr_last;
  } sts_t;

  // Reduce a variable index into the store by repeated compare and subtract.
  function automatic logic [VIDX_W-1:0] var_mod(input logic [VIDX_W-1:0] vi,
                                                input int unsigned count);
    logic [31:0] r;
    logic [31:0] d;
    r = 32'(vi);
    for (int k = VIDX_W - 1; k >= 0; k--) begin
      d = 32'(count) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[VIDX_W-1:0];
  endfunction

endpackage

// ===== design/smeu_in_if.sv =====
interface smeu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [3:0]                            opcode;
  logic signed [smeu_pkg::WORD_W-1:0]    immediate;
  logic [smeu_pkg::VIDX_W-1:0]           var_index;
  logic signed [smeu_pkg::WORD_W-1:0]    increment;
  logic [smeu_pkg::TGT_W-1:0]            jump_target;

  modport source (output valid, opcode, immediate, var_index, increment, jump_target,
                  input ready);
  modport sink (input valid, opcode, immediate, var_index, increment, jump_target,
                output ready);
endinterface

// ===== design/smeu_out_if.sv =====
interface smeu_out_if #(
  parameter int unsigned PCW = 11
);
  logic                               valid;
  logic                               ready;
  logic [PCW-1:0]                     next_pc;
  logic                               print_valid;
  logic signed [smeu_pkg::WORD_W-1:0] print_value;
  logic [1:0]                         error_code;

  modport source (output valid, next_pc, print_valid, print_value, error_code,
                  input ready);
  modport sink (input valid, next_pc, print_valid, print_value, error_code,
                output ready);
endinterface

// ===== design/smeu_div.sv =====
module smeu_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [smeu_pkg::WORD_W-1:0]  dividend,
  input  logic [smeu_pkg::WORD_W-1:0]  divisor,
  output logic                         done,
  output logic [smeu_pkg::WORD_W-1:0]  quotient
);
  localparam int unsigned W  = smeu_pkg::WORD_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]   rem_r;
  logic [W-1:0]   quo_r;
  logic [W-1:0]   den_r;
  logic           neg_r;
  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [W:0]     shifted;
  logic [W+1:0]   diff;

  // one restoring step per cycle
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};

  // control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: take magnitudes on start, then shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[W-1] ? (W'(0) - dividend) : dividend;
      den_r <= divisor[W-1] ? (W'(0) - divisor) : divisor;
      neg_r <= dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      rem_r <= diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
      quo_r <= {quo_r[W-2:0], ~diff[W+1]};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (W'(0) - quo_r) : quo_r;
endmodule

// ===== design/smeu_datapath.sv =====
module smeu_datapath #(
  parameter int unsigned STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VAR_COUNT   = smeu_pkg::VAR_COUNT_DEF,
  parameter int unsigned PROG_DEPTH  = smeu_pkg::PROG_DEPTH_DEF,
  parameter int unsigned PCW         = $clog2(PROG_DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  smeu_pkg::cmd_t                     cmd,
  output smeu_pkg::sts_t                     sts,
  input  logic [3:0]                         in_opcode,
  input  logic [smeu_pkg::WORD_W-1:0]        in_immediate,
  input  logic [smeu_pkg::VIDX_W-1:0]        in_var_index,
  input  logic [smeu_pkg::WORD_W-1:0]        in_increment,
  input  logic [smeu_pkg::TGT_W-1:0]         in_jump_target,
  output logic [PCW-1:0]                     out_next_pc,
  output logic                               out_print_valid,
  output logic [smeu_pkg::WORD_W-1:0]        out_print_value,
  output logic [1:0]                         out_error_code
);
  localparam int unsigned W   = smeu_pkg::WORD_W;
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int unsigned CW  = smeu_pkg::PC_CMP_W;

  smeu_pkg::op_t           op_r;
  logic [W-1:0]            imm_r;
  logic [W-1:0]            inc_r;
  logic [VAW-1:0]          vi_r;
  logic [smeu_pkg::TGT_W-1:0] tgt_r;
  logic [PCW-1:0]          pc_r;
  logic [PCW-1:0]          pc_nxt;
  logic [SPW-1:0]          sp_r;
  logic [SPW-1:0]          sp_nxt;
  logic [W-1:0]            tos_r;
  logic [W-1:0]            tos_nxt;
  logic [W-1:0]            rd_a_r;
  logic [W-1:0]            rd_b_r;
  logic [W-1:0]            var_rd_r;
  logic [VAW-1:0]          clr_cnt_r;
  logic [PCW-1:0]          next_pc_r;
  logic                    print_valid_r;
  logic [W-1:0]            print_value_r;
  logic [1:0]              error_r;

  logic [W-1:0]            stk_mem [STACK_DEPTH];
  logic [W-1:0]            var_mem [VAR_COUNT];

  logic [VAW-1:0]          vi_in;
  logic [SPW-1:0]          sp_m1;
  logic [SPW-1:0]          sp_m2;
  logic [SPW-1:0]          sp_m3;
  logic [CW-1:0]           npc_c;
  logic [CW-1:0]           tgt_c;
  logic [W-1:0]            alu_res;
  logic [W-1:0]            div_q;
  logic                    div_done;
  logic                    var_we;
  logic [VAW-1:0]          var_wa;
  logic [W-1:0]            var_wd;

  assign vi_in = VAW'(smeu_pkg::var_mod(in_var_index, VAR_COUNT));
  assign sp_m1 = sp_r - SPW'(1);
  assign sp_m2 = sp_r - SPW'(2);
  assign sp_m3 = sp_r - SPW'(3);

  // capture the word on accept
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= smeu_pkg::op_t'(in_opcode);
      imm_r <= in_immediate;
      inc_r <= in_increment;
      vi_r  <= vi_in;
      tgt_r <= in_jump_target;
    end
  end

  // operand stack below the top: two reads on accept, one write on push
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rd_a_r <= stk_mem[sp_m2[SAW-1:0]];
      rd_b_r <= stk_mem[sp_m3[SAW-1:0]];
    end
    if (cmd.commit && cmd.push && (sp_r != '0)) begin
      stk_mem[sp_m1[SAW-1:0]] <= tos_r;
    end
  end

  // variable store write select: clearing sweep, store or increment
  always_comb begin
    var_we = cmd.clr | (cmd.commit & (cmd.var_wr_tos | cmd.var_wr_inc));
    var_wa = cmd.clr ? clr_cnt_r : vi_r;
    if (cmd.clr) begin
      var_wd = '0;
    end else if (cmd.var_wr_tos) begin
      var_wd = tos_r;
    end else begin
      var_wd = var_rd_r + inc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      var_rd_r <= var_mem[vi_in];
    end
    if (var_we) begin
      var_mem[var_wa] <= var_wd;
    end
  end

  // sweep counter for the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // arithmetic on top and below-top
  always_comb begin
    case (op_r)
      smeu_pkg::OP_SUB: alu_res = rd_a_r - tos_r;
      smeu_pkg::OP_MUL: alu_res = W'(tos_r * rd_a_r);
      default:          alu_res = tos_r + rd_a_r;
    endcase
  end

  smeu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rd_a_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // next program counter, saturating at the program depth
  always_comb begin
    npc_c = CW'(pc_r) + CW'(1);
    if (npc_c > CW'(PROG_DEPTH)) begin
      npc_c = CW'(PROG_DEPTH);
    end
    tgt_c = CW'(tgt_r);
    if (tgt_c > CW'(PROG_DEPTH)) begin
      tgt_c = CW'(PROG_DEPTH);
    end
    pc_nxt = cmd.branch ? PCW'(tgt_c) : PCW'(npc_c);
  end

  // stack pointer and top of stack
  always_comb begin
    sp_nxt  = sp_r;
    tos_nxt = tos_r;
    if (cmd.push) begin
      sp_nxt  = sp_r + SPW'(1);
      tos_nxt = cmd.push_var ? var_rd_r : imm_r;
    end else if (cmd.pop1) begin
      sp_nxt  = sp_m1;
      tos_nxt = rd_a_r;
    end else if (cmd.pop2) begin
      sp_nxt  = sp_m2;
      tos_nxt = rd_b_r;
    end else if (cmd.alu_wr) begin
      sp_nxt  = sp_m1;
      tos_nxt = alu_res;
    end else if (cmd.div_wr) begin
      sp_nxt  = sp_m1;
      tos_nxt = div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      sp_r <= '0;
    end else if (cmd.commit) begin
      pc_r <= pc_nxt;
      sp_r <= sp_nxt;
    end
  end

  // top of stack and result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tos_r         <= tos_nxt;
      next_pc_r     <= pc_nxt;
      print_valid_r <= cmd.print;
      print_value_r <= cmd.print ? tos_r : '0;
      error_r       <= cmd.err;
    end
  end

  always_comb begin
    sts.op       = op_r;
    sts.sp_zero  = (sp_r == '0);
    sts.sp_lt2   = (sp_r < SPW'(2));
    sts.sp_full  = (sp_r == SPW'(STACK_DEPTH));
    sts.a_zero   = (tos_r == '0);
    sts.b_lt_a   = ($signed(rd_a_r) < $signed(tos_r));
    sts.a_lt_b   = ($signed(tos_r) < $signed(rd_a_r));
    sts.div_done = div_done;
    sts.clr_last = (clr_cnt_r == VAW'(VAR_COUNT - 1));
  end

  assign out_next_pc     = next_pc_r;
  assign out_print_valid = print_valid_r;
  assign out_print_value = print_value_r;
  assign out_error_code  = error_r;
endmodule

// ===== design/smeu_ctrl.sv =====
module smeu_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  smeu_pkg::sts_t  sts,
  output smeu_pkg::cmd_t  cmd
);
  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_DIV   = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  // sequence: clear the store, accept, execute, wait on divide
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
        case (sts.op) inside
          smeu_pkg::OP_CONST, smeu_pkg::OP_LOAD: begin
            if (sts.sp_full) begin
              cmd.err = smeu_pkg::ERR_FULL;
            end else begin
              cmd.push     = 1'b1;
              cmd.push_var = (sts.op == smeu_pkg::OP_LOAD);
            end
          end
          smeu_pkg::OP_POP, smeu_pkg::OP_STORE, smeu_pkg::OP_IFEQ, smeu_pkg::OP_IFNE: begin
            if (sts.sp_zero) begin
              cmd.err = smeu_pkg::ERR_EMPTY;
            end else begin
              cmd.pop1       = 1'b1;
              cmd.var_wr_tos = (sts.op == smeu_pkg::OP_STORE);
              cmd.branch     = ((sts.op == smeu_pkg::OP_IFEQ) && sts.a_zero) ||
                               ((sts.op == smeu_pkg::OP_IFNE) && !sts.a_zero);
            end
          end
          smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL: begin
            if (sts.sp_lt2) begin
              cmd.err = smeu_pkg::ERR_EMPTY;
            end else begin
              cmd.alu_wr = 1'b1;
            end
          end
          smeu_pkg::OP_DIV: begin
            if (sts.sp_lt2) begin
              cmd.err = smeu_pkg::ERR_EMPTY;
            end else if (sts.a_zero) begin
              cmd.err = smeu_pkg::ERR_DIVZERO;
            end else begin
              cmd.commit    = 1'b0;
              cmd.div_start = 1'b1;
              state_nxt     = ST_DIV;
            end
          end
          smeu_pkg::OP_IFLT, smeu_pkg::OP_IFGT: begin
            if (sts.sp_lt2) begin
              cmd.err = smeu_pkg::ERR_EMPTY;
            end else begin
              cmd.pop2   = 1'b1;
              cmd.branch = (sts.op == smeu_pkg::OP_IFLT) ? sts.b_lt_a : sts.a_lt_b;
            end
          end
          smeu_pkg::OP_PRINT: begin
            if (sts.sp_zero) begin
              cmd.err = smeu_pkg::ERR_EMPTY;
            end else begin
              cmd.print = 1'b1;
            end
          end
          smeu_pkg::OP_INC: begin
            cmd.var_wr_inc = 1'b1;
          end
          smeu_pkg::OP_GOTO: begin
            cmd.branch = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          cmd.div_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end
endmodule

// ===== design/stack_machine_execute_unit.sv =====
// Channel   Dir   Word
// in_ch     in    opcode, immediate, var_index, increment, jump_target
// out_ch    out   next_pc, print_valid, print_value, error_code
//
// An instruction is accepted (stack and variable reads), then executed.
// Divide waits in a busy state on the shift-and-subtract divider.
// After reset the variable store is swept to zero with in_ready low.
// A new word is taken when idle and the result register is empty or being read.
`include "stack_machine_execute_unit_assert.svh"

module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = smeu_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VAR_COUNT   = smeu_pkg::VAR_COUNT_DEF,
  parameter int unsigned PROG_DEPTH  = smeu_pkg::PROG_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  smeu_in_if.sink      in_ch,
  smeu_out_if.source   out_ch
);
  localparam int unsigned PCW = $clog2(PROG_DEPTH + 1);

  smeu_pkg::cmd_t cmd;
  smeu_pkg::sts_t sts;

  smeu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  smeu_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VAR_COUNT   (VAR_COUNT),
    .PROG_DEPTH  (PROG_DEPTH),
    .PCW         (PCW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_immediate    (in_ch.immediate),
    .in_var_index    (in_ch.var_index),
    .in_increment    (in_ch.increment),
    .in_jump_target  (in_ch.jump_target),
    .out_next_pc     (out_ch.next_pc),
    .out_print_valid (out_ch.print_valid),
    .out_print_value (out_ch.print_value),
    .out_error_code  (out_ch.error_code)
  );

  // checks
  `SMEU_ASSERT_IMP(a_accept_room, in_ch.valid && in_ch.ready, !out_ch.valid || out_ch.ready, "word accepted with result register blocked")
  `SMEU_ASSERT_IMP(a_push_room, cmd.commit && cmd.push, !sts.sp_full, "push into full stack")
  `SMEU_ASSERT_IMP(a_div_nonzero, cmd.div_start, !sts.a_zero, "divide started on zero divisor")
  `SMEU_ASSERT_NXT(a_commit_out, cmd.commit, out_ch.valid, "executed word gave no result")
endmodule
